@@ sv/lj_pair_energy_accumulate_defines.svh @@
// ---------------------------------------------------------------------------
// Lennard-Jones pair energy accumulator: assertion macros
// Shared property wrappers clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef LJ_PAIR_ENERGY_ACCUMULATE_DEFINES_SVH
`define LJ_PAIR_ENERGY_ACCUMULATE_DEFINES_SVH

// Same-cycle implication.
`define LJPE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define LJPE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/ljpe_pkg.sv @@
// ---------------------------------------------------------------------------
// Lennard-Jones pair energy accumulator: package
// Widths, register indexes and fixed-point constants.
// ---------------------------------------------------------------------------
package ljpe_pkg;

    localparam int POS_W  = 24;
    localparam int CFG_W  = 32;
    localparam int R2_W   = 48;
    localparam int INV_W  = 36;
    localparam int ACC_W  = 48;
    localparam int TERM_W = 32;
    localparam int IDX_W  = 2;

    localparam logic [IDX_W-1:0] REG_BOX_LEN_SQ   = 2'd0;
    localparam logic [IDX_W-1:0] REG_CUTOFF_SQ    = 2'd1;
    localparam logic [IDX_W-1:0] REG_ENERGY_SHIFT = 2'd2;

    localparam logic [CFG_W-1:0] BOX_LEN_SQ_RST   = 32'h0001_0000;
    localparam logic [CFG_W-1:0] CUTOFF_SQ_RST    = 32'h0006_0000;
    localparam logic [CFG_W-1:0] ENERGY_SHIFT_RST = 32'h0000_0000;

    // Partial remainder of 2^64 once the quotient bits above INV_W are known to be zero.
    localparam logic [R2_W-1:0] DIV_REM_INIT = 48'h0000_1000_0000;
    // r2 below 0.125 in Q16.32.
    localparam logic [R2_W-1:0] NEAR_LIMIT   = 48'h0000_2000_0000;
    localparam logic signed [32:0] ONE_Q24   = 33'sh0_0100_0000;

    localparam logic signed [TERM_W-1:0] TERM_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [TERM_W-1:0] TERM_MIN = 32'sh8000_0000;
    localparam logic signed [ACC_W-1:0]  ACC_MAX  = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [ACC_W-1:0]  ACC_MIN  = 48'sh8000_0000_0000;

endpackage

@@ sv/ljpe_div.sv @@
// ---------------------------------------------------------------------------
// Reciprocal divider
// Restoring radix-2 division of 2^64 by r2, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module ljpe_div
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [ljpe_pkg::R2_W-1:0]    divisor,
    output logic                         done,
    output logic [ljpe_pkg::INV_W-1:0]   quotient
);
    import ljpe_pkg::*;

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [5:0]            cnt_reg, cnt_next;
    logic [R2_W-1:0]       rem_reg, rem_next;
    logic [INV_W-1:0]      q_reg, q_next;
    logic [R2_W:0]         rem_dbl;
    logic [R2_W:0]         rem_sub;
    logic                  ge;

    assign rem_dbl = {rem_reg, 1'b0};
    assign rem_sub = rem_dbl - {1'b0, divisor};
    assign ge      = (rem_dbl >= {1'b0, divisor});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 6'(INV_W - 1);
            rem_next  = DIV_REM_INIT;
            q_next    = '0;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? rem_sub[R2_W-1:0] : rem_dbl[R2_W-1:0];
            q_next   = {q_reg[INV_W-2:0], ge};
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

@@ sv/lj_pair_energy_accumulate.sv @@
// ---------------------------------------------------------------------------
// Lennard-Jones pair energy accumulator
// Truncated, shifted LJ energy of particle pairs summed into a saturating sum.
// ---------------------------------------------------------------------------
//  channel   dir  handshake                content
//  s_axis    in   tvalid/tready            one pair of positions, skip flag, last mark
//  m_axis    out  tvalid/tready            energy sum and saturation flag
//  cfg       in   cfg_wr_en                box_len_sq, cutoff_sq, energy_shift
//
//  A pair inside the cutoff waits on the one-bit-per-cycle reciprocal divider between
//  its passes through the single shared 33x33 multiplier. A pair that saturates after
//  the cube skips the last multiply and the term clamp. A pair beyond the cutoff or too
//  close skips the divider and the multiplies after it; a skipped pair is only marked done.
//  s_axis_tready is high only while the sequencer is idle.
//  The result sits in an output register; a last pair waits only if that register is
//  still full. Reset loads the register defaults and clears the sum.
// ---------------------------------------------------------------------------
`include "lj_pair_energy_accumulate_defines.svh"

module lj_pair_energy_accumulate
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // pos_a_x, pos_a_y, pos_a_z, pos_b_x, pos_b_y, pos_b_z
    input  logic [6*ljpe_pkg::POS_W-1:0]  s_axis_tdata,
    // skip_pair
    input  logic                          s_axis_tuser,
    input  logic                          s_axis_tlast,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // energy_sum
    output logic [ljpe_pkg::ACC_W-1:0]    m_axis_tdata,
    // saturated
    output logic                          m_axis_tuser,
    input  logic                          cfg_wr_en,
    input  logic [ljpe_pkg::IDX_W-1:0]    cfg_index,
    input  logic [ljpe_pkg::CFG_W-1:0]    cfg_wdata
);
    import ljpe_pkg::*;

    typedef enum logic [15:0] {
        ST_IDLE = 16'h0001,
        ST_SQX  = 16'h0002,
        ST_SQY  = 16'h0004,
        ST_SQZ  = 16'h0008,
        ST_SUM  = 16'h0010,
        ST_MH   = 16'h0020,
        ST_ML   = 16'h0040,
        ST_R2   = 16'h0080,
        ST_CHK  = 16'h0100,
        ST_DIV  = 16'h0200,
        ST_M1   = 16'h0400,
        ST_M2   = 16'h0800,
        ST_U    = 16'h1000,
        ST_M3   = 16'h2000,
        ST_TRM  = 16'h4000,
        ST_ACC  = 16'h8000
    } state_t;

    state_t state_reg, state_next;
    logic   fin_reg, fin_next;

    logic [CFG_W-1:0]          box_reg, cutoff_reg;
    logic signed [CFG_W-1:0]   shift_reg;

    logic signed [POS_W-1:0]   dx_reg, dy_reg, dz_reg;
    logic                      last_reg;
    logic [R2_W-1:0]           s_reg;
    logic [55:0]               a_reg;
    logic signed [65:0]        p_reg;
    logic [R2_W-1:0]           r2_reg;
    logic [27:0]               inv24_reg;
    logic [30:0]               u_reg;
    logic signed [TERM_W-1:0]  term_reg;
    logic                      term_sat_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic                      sat_seen_reg;
    logic                      out_valid_reg;
    logic [ACC_W-1:0]          out_sum_reg;
    logic                      out_sat_reg;

    logic signed [32:0]        mul_a, mul_b;
    logic signed [65:0]        mul_p;
    logic [56:0]               lo_sum;
    logic [R2_W-1:0]           r2_calc;
    logic signed [35:0]        e_val;
    logic signed [36:0]        t_val;
    logic signed [ACC_W:0]     sum_val;
    logic                      div_start, div_done;
    logic [INV_W-1:0]          div_q;
    logic                      in_fire, out_load;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_load = fin_reg && last_reg && (!out_valid_reg || m_axis_tready);

    // Shared multiplier; every product lands in p_reg for the following state.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_SQX:
            begin
                mul_a = 33'(dx_reg);
                mul_b = 33'(dx_reg);
            end
            ST_SQY:
            begin
                mul_a = 33'(dy_reg);
                mul_b = 33'(dy_reg);
            end
            ST_SQZ:
            begin
                mul_a = 33'(dz_reg);
                mul_b = 33'(dz_reg);
            end
            ST_MH:
            begin
                mul_a = {9'b0, s_reg[47:24]};
                mul_b = {1'b0, box_reg};
            end
            ST_ML:
            begin
                mul_a = {9'b0, s_reg[23:0]};
                mul_b = {1'b0, box_reg};
            end
            ST_M1:
            begin
                mul_a = {5'b0, inv24_reg};
                mul_b = {5'b0, inv24_reg};
            end
            ST_M2:
            begin
                mul_a = {2'b0, p_reg[54:24]};
                mul_b = {5'b0, inv24_reg};
            end
            ST_M3:
            begin
                mul_a = {2'b0, u_reg};
                mul_b = {2'b0, u_reg} - ONE_Q24;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // r2 = floor(s * box / 2^32) from the two partial products.
    assign lo_sum  = {25'b0, a_reg[7:0], 24'b0} + {1'b0, p_reg[55:0]};
    assign r2_calc = a_reg[55:8] + {23'b0, lo_sum[56:32]};

    assign e_val   = p_reg[65:30];
    assign t_val   = 37'(e_val) - 37'(shift_reg);
    assign sum_val = 49'(acc_reg) + 49'(term_reg);

    assign div_start = (state_reg == ST_CHK) && (r2_reg <= {cutoff_reg, 16'b0})
                       && (r2_reg >= NEAR_LIMIT);

    ljpe_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .divisor  (r2_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        state_next = state_reg;
        fin_next   = fin_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (fin_reg)
                begin
                    if (!last_reg || out_load)
                        fin_next = 1'b0;
                end
                else if (in_fire)
                begin
                    if (s_axis_tuser)
                        fin_next = 1'b1;
                    else
                        state_next = ST_SQX;
                end
            end
            ST_SQX: state_next = ST_SQY;
            ST_SQY: state_next = ST_SQZ;
            ST_SQZ: state_next = ST_SUM;
            ST_SUM: state_next = ST_MH;
            ST_MH:  state_next = ST_ML;
            ST_ML:  state_next = ST_R2;
            ST_R2:  state_next = ST_CHK;
            ST_CHK: state_next = div_start ? ST_DIV : ST_ACC;
            ST_DIV:
            begin
                if (div_done)
                    state_next = ST_M1;
            end
            ST_M1:  state_next = ST_M2;
            ST_M2:  state_next = ST_U;
            ST_U:   state_next = (|p_reg[57:55]) ? ST_ACC : ST_M3;
            ST_M3:  state_next = ST_TRM;
            ST_TRM: state_next = ST_ACC;
            ST_ACC:
            begin
                state_next = ST_IDLE;
                fin_next   = 1'b1;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign s_axis_tready = (state_reg == ST_IDLE) && !fin_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fin_reg       <= 1'b0;
            box_reg       <= BOX_LEN_SQ_RST;
            cutoff_reg    <= CUTOFF_SQ_RST;
            shift_reg     <= ENERGY_SHIFT_RST;
            acc_reg       <= '0;
            sat_seen_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fin_reg   <= fin_next;
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_BOX_LEN_SQ:   box_reg    <= cfg_wdata;
                    REG_CUTOFF_SQ:    cutoff_reg <= cfg_wdata;
                    REG_ENERGY_SHIFT: shift_reg  <= cfg_wdata;
                    default:          ;
                endcase
            end
            if (state_reg == ST_ACC)
            begin
                if (sum_val > 49'(ACC_MAX))
                begin
                    acc_reg      <= ACC_MAX;
                    sat_seen_reg <= 1'b1;
                end
                else if (sum_val < 49'(ACC_MIN))
                begin
                    acc_reg      <= ACC_MIN;
                    sat_seen_reg <= 1'b1;
                end
                else
                begin
                    acc_reg <= sum_val[ACC_W-1:0];
                    if (term_sat_reg)
                        sat_seen_reg <= 1'b1;
                end
            end
            if (out_load)
            begin
                acc_reg       <= '0;
                sat_seen_reg  <= 1'b0;
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        p_reg <= mul_p;
        if (in_fire)
        begin
            dx_reg   <= s_axis_tdata[23:0]    - s_axis_tdata[95:72];
            dy_reg   <= s_axis_tdata[47:24]   - s_axis_tdata[119:96];
            dz_reg   <= s_axis_tdata[71:48]   - s_axis_tdata[143:120];
            last_reg <= s_axis_tlast;
        end
        case (state_reg)
            ST_SQY: s_reg <= p_reg[47:0];
            ST_SQZ: s_reg <= s_reg + p_reg[47:0];
            ST_SUM: s_reg <= s_reg + p_reg[47:0];
            ST_ML:  a_reg <= p_reg[55:0];
            ST_R2:  r2_reg <= r2_calc;
            ST_CHK:
            begin
                if (r2_reg > {cutoff_reg, 16'b0})
                begin
                    term_reg     <= '0;
                    term_sat_reg <= 1'b0;
                end
                else
                begin
                    term_reg     <= TERM_MAX;
                    term_sat_reg <= 1'b1;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                    inv24_reg <= div_q[35:8];
            end
            ST_U:
            begin
                u_reg        <= p_reg[54:24];
                term_reg     <= TERM_MAX;
                term_sat_reg <= 1'b1;
            end
            ST_TRM:
            begin
                if (t_val > 37'(TERM_MAX))
                begin
                    term_reg     <= TERM_MAX;
                    term_sat_reg <= 1'b1;
                end
                else if (t_val < 37'(TERM_MIN))
                begin
                    term_reg     <= TERM_MIN;
                    term_sat_reg <= 1'b1;
                end
                else
                begin
                    term_reg     <= t_val[TERM_W-1:0];
                    term_sat_reg <= 1'b0;
                end
            end
            default: ;
        endcase
        if (out_load)
        begin
            out_sum_reg <= acc_reg;
            out_sat_reg <= sat_seen_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_sum_reg;
    assign m_axis_tuser  = out_sat_reg;

    `LJPE_ASSERT_NXT(a_busy_after_accept, in_fire, !s_axis_tready,
        "input accepted while a pair is in flight")
    `LJPE_ASSERT_IMP(a_div_done_in_div, div_done, state_reg == ST_DIV,
        "divider finished outside the divide step")
    `LJPE_ASSERT_NXT(a_clear_after_emit, out_load, acc_reg == '0 && !sat_seen_reg,
        "sum not cleared after emitting a result")
    `LJPE_ASSERT_NXT(a_emit_valid, out_load, m_axis_tvalid,
        "emitted result not presented")

endmodule

@@ sim/tb_top.sv @@
// ---------------------------------------------------------------------------
// Testbench for the Lennard-Jones pair energy accumulator
// Streams particle pairs in frames, predicts each frame's saturating energy
// sum with a fixed-point model of the pair term, and checks every result word.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

    import ljpe_pkg::*;

    localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 2000000;
    // Worst case pair time plus margin; used before register writes and at the end.
    localparam int SETTLE_CYCLES = 120;

    typedef struct {
        logic [POS_W-1:0] ax, ay, az, bx, by, bz;
        bit skip;
        bit last;
    } pair_t;

    typedef struct {
        logic [ACC_W-1:0] sum;
        bit sat;
    } frame_result_t;

    logic clk;
    logic rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [6*POS_W-1:0] s_axis_tdata;
    logic s_axis_tuser;
    logic s_axis_tlast;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [ACC_W-1:0] m_axis_tdata;
    logic m_axis_tuser;
    logic cfg_wr_en;
    logic [IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_wdata;

    // Predictor state
    logic [CFG_W-1:0] box_len_sq_q;
    logic [CFG_W-1:0] cutoff_sq_q;
    logic signed [CFG_W-1:0] energy_shift_q;
    longint energy_total;
    bit sat_pending;
    frame_result_t frame_sums[$];

    int errors;
    int pairs_sent;
    int frames_checked;
    int sat_frames;
    longint cycle_count;
    bit tx_quiet;
    bit rx_quiet;
    int rx_hold;

    lj_pair_energy_accumulate DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Pair energy in Q16.16, clamped; sat reports any clamp.
    function automatic longint lj_pair_term(pair_t p, output bit sat);
        logic signed [POS_W-1:0] dx, dy, dz;
        longint dxl, dyl, dzl;
        logic [127:0] scaled;
        logic [127:0] recip;
        longint unsigned dist_sq, r2, inv24, i2, cut;
        longint u, e, t;
        sat = 1'b0;
        dx = p.ax - p.bx;
        dy = p.ay - p.by;
        dz = p.az - p.bz;
        dxl = dx;
        dyl = dy;
        dzl = dz;
        dist_sq = dxl * dxl + dyl * dyl + dzl * dzl;
        scaled = 128'(dist_sq) * 128'(box_len_sq_q);
        r2 = 64'(scaled >> 32);
        cut = 64'(cutoff_sq_q) << 16;
        if (r2 > cut)
            return 0;
        if (r2 < 64'(NEAR_LIMIT))
        begin
            sat = 1'b1;
            return longint'(TERM_MAX);
        end
        recip = (128'd1 << 64) / 128'(r2);
        inv24 = 64'(recip >> 8);
        i2 = (inv24 * inv24) >> 24;
        u = longint'((i2 * inv24) >> 24);
        if (u >= (longint'(128) << 24))
        begin
            sat = 1'b1;
            return longint'(TERM_MAX);
        end
        e = (u * (u - (longint'(1) << 24))) >>> 30;
        t = e - longint'(energy_shift_q);
        if (t > longint'(TERM_MAX))
        begin
            sat = 1'b1;
            return longint'(TERM_MAX);
        end
        if (t < longint'(TERM_MIN))
        begin
            sat = 1'b1;
            return longint'(TERM_MIN);
        end
        return t;
    endfunction

    function automatic void accumulate_pair(pair_t p);
        frame_result_t r;
        longint term, total;
        bit sat;
        if (!p.skip)
        begin
            term = lj_pair_term(p, sat);
            total = energy_total + term;
            if (total > longint'(ACC_MAX))
            begin
                total = longint'(ACC_MAX);
                sat = 1'b1;
            end
            if (total < longint'(ACC_MIN))
            begin
                total = longint'(ACC_MIN);
                sat = 1'b1;
            end
            energy_total = total;
            if (sat)
                sat_pending = 1'b1;
        end
        if (p.last)
        begin
            r.sum = energy_total[ACC_W-1:0];
            r.sat = sat_pending;
            frame_sums.push_back(r);
            energy_total = 0;
            sat_pending = 1'b0;
        end
    endfunction

    // Sends one pair; tvalid stays high for a following pair unless a random gap is put in, which tx_quiet turns off.
    task automatic send_pair(pair_t p);
        if (!tx_quiet && $urandom_range(99) < 36)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        s_axis_tdata <= {p.bz, p.by, p.bx, p.az, p.ay, p.ax};
        s_axis_tuser <= p.skip;
        s_axis_tlast <= p.last;
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        accumulate_pair(p);
        pairs_sent++;
        @(negedge clk);
    endtask

    // Waits for all sums and for any trailing pair to finish.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (frame_sums.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_regs(logic [CFG_W-1:0] box, logic [CFG_W-1:0] cut,
                            logic [CFG_W-1:0] shift);
        logic [CFG_W-1:0] vals[3];
        vals = '{box, cut, shift};
        wait_idle();
        for (int i = 0; i < 3; i++)
        begin
            cfg_wr_en <= 1'b1;
            cfg_index <= IDX_W'(i);
            cfg_wdata <= vals[i];
            @(negedge clk);
        end
        cfg_wr_en <= 1'b0;
        box_len_sq_q = box;
        cutoff_sq_q = cut;
        energy_shift_q = shift;
    endtask

    function automatic pair_t make_pair(logic [POS_W-1:0] ax, logic [POS_W-1:0] ay,
                                        logic [POS_W-1:0] az, logic [POS_W-1:0] bx,
                                        logic [POS_W-1:0] by, logic [POS_W-1:0] bz,
                                        bit skip, bit last);
        pair_t p;
        p.ax = ax; p.ay = ay; p.az = az;
        p.bx = bx; p.by = by; p.bz = bz;
        p.skip = skip;
        p.last = last;
        return p;
    endfunction

    // Random pair whose separation spans a random number of octaves.
    function automatic pair_t random_pair(bit last);
        pair_t p;
        int k;
        k = $urandom_range(6, 23);
        p.ax = POS_W'($urandom);
        p.ay = POS_W'($urandom);
        p.az = POS_W'($urandom);
        p.bx = p.ax + POS_W'($urandom_range(0, (1 << k) - 1) - (1 << (k - 1)));
        p.by = p.ay + POS_W'($urandom_range(0, (1 << k) - 1) - (1 << (k - 1)));
        p.bz = p.az + POS_W'($urandom_range(0, (1 << k) - 1) - (1 << (k - 1)));
        if ($urandom_range(99) < 5)
        begin
            p.bx = p.ax; p.by = p.ay; p.bz = p.az;
        end
        p.skip = ($urandom_range(99) < 10);
        p.last = last;
        return p;
    endfunction

    task automatic send_frames(int n_pairs);
        int left;
        int len;
        left = n_pairs;
        while (left > 0)
        begin
            len = $urandom_range(1, 10);
            if (len > left)
                len = left;
            for (int i = 0; i < len; i++)
                send_pair(random_pair(i == len - 1));
            left -= len;
        end
    endtask

    task automatic test_directed();
        logic [POS_W-1:0] tenth, fifth, half;
        tenth = POS_W'(1677722);
        fifth = POS_W'(3355443);
        half = POS_W'(11863283);
        // Coincident particles, the wrap from the top of the range to the bottom, and skipped pairs.
        send_pair(make_pair('0, '0, '0, '0, '0, '0, 1'b0, 1'b0));
        send_pair(make_pair(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF,
                            24'h800000, 24'h800000, 24'h800000, 1'b0, 1'b0));
        send_pair(make_pair(24'h800000, 24'h800000, 24'h800000, '0, '0, '0, 1'b0, 1'b1));
        send_pair(make_pair(24'h123456, 24'hABCDEF, 24'h0F0F0F, '0, '0, '0, 1'b1, 1'b1));
        send_pair(make_pair('0, '0, '0, '0, '0, '0, 1'b1, 1'b0));
        send_pair(make_pair(24'h7FFFFF, '0, '0, 24'h800000, '0, '0, 1'b1, 1'b1));
        // Box of 10: a pair inside the cutoff and two beyond it.
        set_regs(32'd100 << 16, CUTOFF_SQ_RST, ENERGY_SHIFT_RST);
        send_pair(make_pair(tenth, tenth, tenth, '0, '0, '0, 1'b0, 1'b1));
        send_pair(make_pair(fifth, fifth, fifth, '0, '0, '0, 1'b0, 1'b0));
        send_pair(make_pair(half, 24'h000000, 24'h000000, '0, '0, '0, 1'b0, 1'b1));
        // Shift extremes: the most negative on a pair inside the cutoff, the most positive on pairs beyond it.
        set_regs(32'd100 << 16, CUTOFF_SQ_RST, 32'h8000_0000);
        send_pair(make_pair(tenth, tenth, tenth, '0, '0, '0, 1'b0, 1'b1));
        set_regs(32'd100 << 16, CUTOFF_SQ_RST, 32'h7FFF_FFFF);
        send_pair(make_pair(half, '0, '0, '0, '0, '0, 1'b0, 1'b1));
        send_pair(make_pair(fifth, fifth, fifth, '0, '0, '0, 1'b0, 1'b1));
        // Largest box and cutoff, then a write to an unused index that must be ignored.
        set_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, ENERGY_SHIFT_RST);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_UNUSED;
        cfg_wdata <= 32'h0000_0001;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        send_pair(make_pair(24'h000100, 24'h000200, 24'h000300, '0, '0, '0, 1'b0, 1'b0));
        send_pair(make_pair(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, '0, '0, '0, 1'b0, 1'b1));
        // Zero box gives r2 of zero; so do a one-LSB and a coincident pair under the zero cutoff.
        set_regs('0, '0, ENERGY_SHIFT_RST);
        send_pair(make_pair(24'h400000, '0, '0, '0, '0, '0, 1'b0, 1'b1));
        set_regs(BOX_LEN_SQ_RST, '0, 32'hFFFF_0000);
        send_pair(make_pair(24'h000001, '0, '0, '0, '0, '0, 1'b0, 1'b1));
        send_pair(make_pair('0, '0, '0, '0, '0, '0, 1'b0, 1'b1));
    endtask

    task automatic test_random_settings();
        logic [CFG_W-1:0] box, cut, shift;
        for (int ph = 0; ph < 12; ph++)
        begin
            box = (CFG_W'($urandom_range(1, 400)) << 16) | CFG_W'($urandom_range(0, 65535));
            if ($urandom_range(9) == 0)
                box = CFG_W'($urandom);
            cut = (CFG_W'($urandom_range(1, 12)) << 16) | CFG_W'($urandom_range(0, 65535));
            shift = CFG_W'($urandom_range(0, 131071) - 65536);
            if ($urandom_range(7) == 0)
                shift = CFG_W'($urandom);
            set_regs(box, cut, shift);
            send_frames(75);
        end
    endtask

    task automatic test_output_stall();
        set_regs(32'd25 << 16, CUTOFF_SQ_RST, 32'hFFFF_FF00);
        rx_hold = 3000;
        send_frames(60);
    endtask

    task automatic test_no_idle();
        set_regs(32'd49 << 16, 32'd9 << 16, ENERGY_SHIFT_RST);
        tx_quiet = 1'b1;
        rx_quiet = 1'b1;
        send_frames(150);
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
    endtask

    task automatic test_wide_random();
        set_regs(32'd36 << 16, 32'd6 << 16, 32'h0000_0400);
        send_frames(400);
    endtask

    // Receiver stall; a long hold-off is counted down here.
    always @(negedge clk)
    begin
        if (rx_hold > 0)
        begin
            m_axis_tready <= 1'b0;
            rx_hold <= rx_hold - 1;
        end
        else if (rx_quiet)
            m_axis_tready <= 1'b1;
        else
            m_axis_tready <= ($urandom_range(99) >= 36);
    end

    always @(posedge clk)
    begin
        frame_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (frame_sums.size() == 0)
            begin
                $display("%0t: unexpected energy word sum=%h sat=%b", $time,
                         m_axis_tdata, m_axis_tuser);
                errors++;
            end
            else
            begin
                want = frame_sums.pop_front();
                frames_checked++;
                if (want.sat)
                    sat_frames++;
                if (m_axis_tdata !== want.sum)
                begin
                    $display("%0t: energy_sum expected %h actual %h", $time, want.sum,
                             m_axis_tdata);
                    errors++;
                end
                if (m_axis_tuser !== want.sat)
                begin
                    $display("%0t: saturated expected %b actual %b", $time, want.sat,
                             m_axis_tuser);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d sums outstanding", $time, frame_sums.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        s_axis_tlast = 1'b0;
        m_axis_tready = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        errors = 0;
        pairs_sent = 0;
        frames_checked = 0;
        sat_frames = 0;
        cycle_count = 0;
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
        rx_hold = 0;
        box_len_sq_q = BOX_LEN_SQ_RST;
        cutoff_sq_q = CUTOFF_SQ_RST;
        energy_shift_q = ENERGY_SHIFT_RST;
        energy_total = 0;
        sat_pending = 1'b0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_random_settings();
        test_output_stall();
        test_no_idle();
        test_wide_random();
        wait_idle();

        $display("Sent %0d pairs over directed, random, stalled and gap-free phases.",
                 pairs_sent);
        $display("Checked %0d frame sums, %0d of them with saturation flagged.",
                 frames_checked, sat_frames);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
